FILE: rtl/lpt_pkg.sv
// ----------------------------------------------------------------------------
// lpt_pkg
// Shared types and constants of the long press tracker.
// ----------------------------------------------------------------------------
package lpt_pkg;

  localparam int unsigned SLOTS_DEF = 8;
  localparam int unsigned FramesW   = 24;
  localparam logic [FramesW-1:0] FRAMES_RESET = 24'd44100;

  typedef struct packed {
    logic               cmd;
    logic        [15:0] press_id;
    logic               is_release;
    logic               has_sustain;
    logic               long_pressable;
    logic        [15:0] symbol_id;
    logic signed [31:0] press_value;
    logic        [15:0] frame_count;
  } in_t;

  typedef struct packed {
    logic        [15:0] fired_id;
    logic        [15:0] fired_symbol;
    logic signed [31:0] fired_value;
    logic               last;
  } out_t;

  typedef struct packed {
    logic        [15:0]        id;
    logic        [15:0]        symbol;
    logic signed [31:0]        value;
    logic        [FramesW-1:0] frames;
  } slot_dat_t;

  typedef struct packed {
    logic      used;
    logic      fire;
    slot_dat_t dat;
  } slot_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INSERT,
    OP_EVENT,
    OP_TICK,
    OP_ROTATE,
    OP_COMPACT
  } cell_op_e;

  typedef struct packed {
    cell_op_e            op;
    logic [15:0]         id;
    logic [15:0]         symbol;
    logic                is_release;
    logic [15:0]         add;
    logic [FramesW-1:0]  thr;
  } cell_ctl_t;

  typedef struct packed {
    logic any_match;
    logic full;
    logic any_fire;
    logic fire_head;
    logic fire_rest;
    logic compact;
    logic out_free;
  } stat_t;

  typedef struct packed {
    cell_op_e op;
    logic     emit;
    logic     last;
  } ctrl_t;

endpackage

FILE: rtl/long_press_tracker.sv
// ----------------------------------------------------------------------------
// long_press_tracker
// Tracks held triggers in an age-ordered chain of slot cells and reports
// presses that stay down until they reach the frame threshold.
// ----------------------------------------------------------------------------
//  channel  | direction | payload            | handshake
//  in       | input     | lpt_pkg::in_t      | in_valid_i / in_ready_o
//  out      | output    | lpt_pkg::out_t     | out_valid_o / out_ready_i
//  cfg      | input     | 24-bit threshold   | cfg_valid_i / cfg_ready_o
//
//  Cell 0 holds the newest press; held slots are packed at the head when idle.
//  Event: updates, removes or inserts a press; a release then compacts.
//  Tick: ages every held slot; if any fires, the ring rotates through all
//  SLOTS cells, then compacts; rotation halts while a fired head entry waits.
//  Reset empties every slot and loads the threshold with 44100.
// ----------------------------------------------------------------------------
module long_press_tracker #(
  parameter int unsigned SLOTS = lpt_pkg::SLOTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  lpt_pkg::in_t                in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output lpt_pkg::out_t               out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [lpt_pkg::FramesW-1:0] cfg_data_i
);

  logic [lpt_pkg::FramesW-1:0] thr_q;
  lpt_pkg::in_t                item_q;
  logic                        out_valid_q;
  lpt_pkg::out_t               out_data_q;

  lpt_pkg::cell_ctl_t cell_ctl;
  lpt_pkg::stat_t     stat;
  lpt_pkg::ctrl_t     ctl;
  lpt_pkg::slot_t     new_ent;
  lpt_pkg::slot_t     tail_in;
  lpt_pkg::slot_t     pass [SLOTS];
  logic [SLOTS-1:0]   used, fire, match;
  logic [SLOTS:0]     hole;

  assign cfg_ready_o = 1'b1;

  lpt_ctrl #(.SLOTS(SLOTS)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .item_i     (item_q),
    .stat_i     (stat),
    .in_ready_o (in_ready_o),
    .ctl_o      (ctl)
  );

  always_comb begin
    cell_ctl.op         = ctl.op;
    cell_ctl.id         = item_q.press_id;
    cell_ctl.symbol     = item_q.symbol_id;
    cell_ctl.is_release = item_q.is_release;
    cell_ctl.add        = item_q.frame_count;
    cell_ctl.thr        = thr_q;

    new_ent.used        = 1'b1;
    new_ent.fire        = 1'b0;
    new_ent.dat.id      = item_q.press_id;
    new_ent.dat.symbol  = item_q.symbol_id;
    new_ent.dat.value   = item_q.press_value;
    new_ent.dat.frames  = '0;

    // the ring closes only while rotating; a fired entry re-enters empty
    if (ctl.op == lpt_pkg::OP_ROTATE) begin
      tail_in      = pass[0];
      tail_in.used = pass[0].used && !pass[0].fire;
      tail_in.fire = 1'b0;
    end else begin
      tail_in = '0;
    end
  end

  assign hole[0] = 1'b0;

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    lpt_pkg::slot_t prev_in, next_in;
    if (k == 0) begin : g_head
      assign prev_in = new_ent;
    end else begin : g_mid
      assign prev_in = pass[k-1];
    end
    if (k == SLOTS - 1) begin : g_tail
      assign next_in = tail_in;
    end else begin : g_body
      assign next_in = pass[k+1];
    end
    lpt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (cell_ctl),
      .prev_i  (prev_in),
      .next_i  (next_in),
      .hole_i  (hole[k]),
      .pass_o  (pass[k]),
      .used_o  (used[k]),
      .fire_o  (fire[k]),
      .match_o (match[k]),
      .hole_o  (hole[k+1])
    );
  end

  always_comb begin
    stat.any_match = |match;
    stat.full      = used[SLOTS-1];
    stat.any_fire  = |fire;
    stat.fire_head = fire[0];
    stat.fire_rest = |(fire >> 1);
    stat.out_free  = !out_valid_q || out_ready_i;
    stat.compact   = 1'b1;
    for (int k = 0; k < SLOTS - 1; k++) begin
      if (!used[k] && used[k+1]) begin
        stat.compact = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= lpt_pkg::FRAMES_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        thr_q <= cfg_data_i;
      end
      if (ctl.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
    if (ctl.emit) begin
      out_data_q.fired_id     <= pass[0].dat.id;
      out_data_q.fired_symbol <= pass[0].dat.symbol;
      out_data_q.fired_value  <= pass[0].dat.value;
      out_data_q.last         <= ctl.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_idle_compact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> stat.compact)
    else $error("slot chain not packed while idle");

  a_idle_no_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !stat.any_fire)
    else $error("pending detection while idle");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.emit |-> (stat.out_free && !in_ready_o))
    else $error("detection issued over a waiting result");

endmodule

FILE: rtl/lpt_cell.sv
// ----------------------------------------------------------------------------
// lpt_cell
// One slot of the tracker chain; shifts, updates and tests its own entry.
// ----------------------------------------------------------------------------
module lpt_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lpt_pkg::cell_ctl_t ctl_i,
  input  lpt_pkg::slot_t     prev_i,
  input  lpt_pkg::slot_t     next_i,
  input  logic               hole_i,
  output lpt_pkg::slot_t     pass_o,
  output logic               used_o,
  output logic               fire_o,
  output logic               match_o,
  output logic               hole_o
);

  logic               used_q, used_d;
  logic               fire_q, fire_d;
  lpt_pkg::slot_dat_t dat_q, dat_d;
  logic [lpt_pkg::FramesW:0] sum;

  assign sum     = {1'b0, dat_q.frames} + (lpt_pkg::FramesW+1)'(ctl_i.add);
  assign match_o = used_q && (dat_q.id == ctl_i.id);
  assign hole_o  = hole_i || !used_q;
  assign used_o  = used_q;
  assign fire_o  = fire_q;

  always_comb begin
    pass_o.used = used_q;
    pass_o.fire = fire_q;
    pass_o.dat  = dat_q;
  end

  always_comb begin
    used_d = used_q;
    fire_d = fire_q;
    dat_d  = dat_q;
    case (ctl_i.op)
      lpt_pkg::OP_INSERT: begin
        used_d = prev_i.used;
        fire_d = prev_i.fire;
        dat_d  = prev_i.dat;
      end
      lpt_pkg::OP_EVENT: begin
        if (match_o) begin
          if (ctl_i.is_release) begin
            used_d = 1'b0;
          end else begin
            dat_d.frames = '0;
            dat_d.symbol = ctl_i.symbol;
          end
        end
      end
      lpt_pkg::OP_TICK: begin
        if (used_q) begin
          if (sum >= {1'b0, ctl_i.thr}) begin
            fire_d = 1'b1;
          end else begin
            dat_d.frames = sum[lpt_pkg::FramesW-1:0];
          end
        end
      end
      lpt_pkg::OP_ROTATE: begin
        used_d = next_i.used;
        fire_d = next_i.fire;
        dat_d  = next_i.dat;
      end
      lpt_pkg::OP_COMPACT: begin
        if (hole_o) begin
          used_d = next_i.used;
          fire_d = next_i.fire;
          dat_d  = next_i.dat;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      fire_q <= 1'b0;
    end else begin
      used_q <= used_d;
      fire_q <= fire_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dat_q <= dat_d;
  end

endmodule

FILE: rtl/lpt_ctrl.sv
// ----------------------------------------------------------------------------
// lpt_ctrl
// Sequencer: decodes a transfer into chain operations and paces emission.
// ----------------------------------------------------------------------------
module lpt_ctrl #(
  parameter int unsigned SLOTS = lpt_pkg::SLOTS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  lpt_pkg::in_t     item_i,
  input  lpt_pkg::stat_t   stat_i,
  output logic             in_ready_o,
  output lpt_pkg::ctrl_t   ctl_o
);

  localparam int unsigned CntW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_CHECK,
    ST_ROTATE,
    ST_COMPACT
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] rot_q, rot_d;
  logic            counted;

  assign counted    = item_i.long_pressable && item_i.has_sustain &&
                      (item_i.press_id != 16'd0);
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d   = state_q;
    rot_d     = rot_q;
    ctl_o.op   = lpt_pkg::OP_HOLD;
    ctl_o.emit = 1'b0;
    ctl_o.last = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_d = ST_IDLE;
        if (item_i.cmd) begin
          ctl_o.op = lpt_pkg::OP_TICK;
          state_d  = ST_CHECK;
        end else if (counted) begin
          if (stat_i.any_match) begin
            ctl_o.op = lpt_pkg::OP_EVENT;
            if (item_i.is_release) begin
              state_d = ST_COMPACT;
            end
          end else if (!item_i.is_release && !stat_i.full) begin
            ctl_o.op = lpt_pkg::OP_INSERT;
          end
        end
      end
      ST_CHECK: begin
        rot_d = '0;
        if (stat_i.any_fire) begin
          state_d = ST_ROTATE;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_ROTATE: begin
        if (!stat_i.fire_head || stat_i.out_free) begin
          ctl_o.op   = lpt_pkg::OP_ROTATE;
          ctl_o.emit = stat_i.fire_head;
          ctl_o.last = !stat_i.fire_rest;
          rot_d      = rot_q + CntW'(1);
          if (rot_q == CntW'(SLOTS - 1)) begin
            state_d = ST_COMPACT;
          end
        end
      end
      ST_COMPACT: begin
        if (stat_i.compact) begin
          state_d = ST_IDLE;
        end else begin
          ctl_o.op = lpt_pkg::OP_COMPACT;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rot_q   <= '0;
    end else begin
      state_q <= state_d;
      rot_q   <= rot_d;
    end
  end

endmodule
